// ----- src/trqs_pkg.sv -----
package trqs_pkg;

	// Fixed field widths of the request and result.
	localparam int PID_W = 8;
	localparam int OP_W = 2;

	// Defaults for the top-level parameters.
	localparam int ID_WIDTH_DEFAULT = 8;
	localparam int QUEUE_DEPTH_DEFAULT = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_END_SLICE = 2'd1;
	localparam logic [OP_W-1:0] OP_TERMINATE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [PID_W-1:0] process_id;
		logic             is_real_time;
	} request_t;

	typedef struct packed {
		logic [PID_W-1:0] running_id;
		logic             running_valid;
		logic             running_real_time;
		logic             dropped;
	} result_t;

	// Occupancy flags that a queue reports to the scheduler control.
	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

// ----- src/two_level_ready_queue_scheduler_unit.sv -----
// Channel   Ports                  Handshake
// request   start, busy, request   taken at a clock edge with start high and busy low
// result    done, result           done high for one cycle; result valid in that cycle
//
// A request that needs no queue read finishes in the execute state; one that pops a
// queue head goes on through the pop state, which takes the registered read of the queue memory.
// busy stays high from the accepting edge until the result is registered, and the
// result strobe overlaps the first cycle in which the next request can be taken.
// Reset empties both queues and clears the running and preempted slots; the
// queue memories themselves are not cleared and need no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module two_level_ready_queue_scheduler_unit #(
	parameter int ID_WIDTH = trqs_pkg::ID_WIDTH_DEFAULT,
	parameter int QUEUE_DEPTH = trqs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  trqs_pkg::request_t request,
	output logic               done,
	output trqs_pkg::result_t  result
);

	localparam int PidW = trqs_pkg::PID_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_POP  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	trqs_pkg::request_t req_q;
	trqs_pkg::result_t  result_q;
	trqs_pkg::result_t  result_d;
	logic               done_q;
	logic               finish;
	logic               drop;

	logic [ID_WIDTH-1:0] pid;
	logic [ID_WIDTH-1:0] run_id_q;
	logic [ID_WIDTH-1:0] run_id_d;
	logic                run_valid_q;
	logic                run_valid_d;
	logic                run_rt_q;
	logic                run_rt_d;
	logic [ID_WIDTH-1:0] pre_id_q;
	logic [ID_WIDTH-1:0] pre_id_d;
	logic                pre_valid_q;
	logic                pre_valid_d;
	logic                pop_rt_q;
	logic                pop_rt_d;
	logic                rotate_q;
	logic                rotate_d;

	logic                    rt_push;
	logic                    rt_pop;
	logic                    reg_push;
	logic                    reg_pop;
	logic [ID_WIDTH-1:0]     push_data;
	logic [ID_WIDTH-1:0]     rt_rd;
	logic [ID_WIDTH-1:0]     reg_rd;
	trqs_pkg::queue_status_t rt_st;
	trqs_pkg::queue_status_t reg_st;

	assign busy = (state_q != ST_IDLE);
	assign pid = ID_WIDTH'(req_q.process_id);

	// Real-time and regular ready queues.
	trqs_queue #(
		.WIDTH(ID_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_rt_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rt_push),
		.push_data(push_data),
		.pop      (rt_pop),
		.pop_data (rt_rd),
		.status   (rt_st)
	);

	trqs_queue #(
		.WIDTH(ID_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_reg_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (reg_push),
		.push_data(push_data),
		.pop      (reg_pop),
		.pop_data (reg_rd),
		.status   (reg_st)
	);

	// Scheduling decisions. A pop reads the queue head in the execute cycle and
	// the popped id is used in the following cycle, where a rotation also pushes
	// the old running id. The queues are touched by one request at a time.
	always_comb begin
		state_d = state_q;
		run_id_d = run_id_q;
		run_valid_d = run_valid_q;
		run_rt_d = run_rt_q;
		pre_id_d = pre_id_q;
		pre_valid_d = pre_valid_q;
		pop_rt_d = pop_rt_q;
		rotate_d = rotate_q;
		rt_push = 1'b0;
		reg_push = 1'b0;
		rt_pop = 1'b0;
		reg_pop = 1'b0;
		push_data = pid;
		finish = 1'b0;
		drop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				finish = 1'b1;
				case (req_q.operation)
					trqs_pkg::OP_ADD: begin
						if (!req_q.is_real_time) begin
							if (!run_valid_q) begin
								run_id_d = pid;
								run_valid_d = 1'b1;
								run_rt_d = 1'b0;
							end else if (reg_st.full) begin
								drop = 1'b1;
							end else begin
								reg_push = 1'b1;
							end
						end else if (rt_st.empty && !run_rt_q) begin
							// A regular process on the CPU is preempted.
							if (run_valid_q) begin
								pre_id_d = run_id_q;
								pre_valid_d = 1'b1;
							end
							run_id_d = pid;
							run_valid_d = 1'b1;
							run_rt_d = 1'b1;
						end else if (rt_st.full) begin
							drop = 1'b1;
						end else begin
							rt_push = 1'b1;
						end
					end
					trqs_pkg::OP_END_SLICE: begin
						// Round-robin within the running class; nothing to do if idle.
						if (run_valid_q && run_rt_q && !rt_st.empty) begin
							rt_pop = 1'b1;
							pop_rt_d = 1'b1;
							rotate_d = 1'b1;
							state_d = ST_POP;
							finish = 1'b0;
						end else if (run_valid_q && !run_rt_q && !reg_st.empty) begin
							reg_pop = 1'b1;
							pop_rt_d = 1'b0;
							rotate_d = 1'b1;
							state_d = ST_POP;
							finish = 1'b0;
						end
					end
					trqs_pkg::OP_TERMINATE: begin
						if (run_rt_q && !rt_st.empty) begin
							rt_pop = 1'b1;
							pop_rt_d = 1'b1;
							rotate_d = 1'b0;
							state_d = ST_POP;
							finish = 1'b0;
						end else if (run_rt_q && pre_valid_q) begin
							// The preempted regular process comes back first.
							run_id_d = pre_id_q;
							run_valid_d = 1'b1;
							run_rt_d = 1'b0;
							pre_valid_d = 1'b0;
						end else begin
							run_rt_d = 1'b0;
							if (!reg_st.empty) begin
								reg_pop = 1'b1;
								pop_rt_d = 1'b0;
								rotate_d = 1'b0;
								state_d = ST_POP;
								finish = 1'b0;
							end else begin
								run_valid_d = 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_POP: begin
				state_d = ST_IDLE;
				finish = 1'b1;
				run_id_d = pop_rt_q ? rt_rd : reg_rd;
				run_valid_d = 1'b1;
				push_data = run_id_q;
				if (rotate_q) begin
					rt_push = pop_rt_q;
					reg_push = !pop_rt_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result as seen after this request.
	always_comb begin
		result_d.running_id = run_valid_d ? PidW'(run_id_d) : '0;
		result_d.running_valid = run_valid_d;
		result_d.running_real_time = run_valid_d && run_rt_d;
		result_d.dropped = drop;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_valid_q <= 1'b0;
			run_rt_q <= 1'b0;
			pre_valid_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			run_valid_q <= run_valid_d;
			run_rt_q <= run_rt_d;
			pre_valid_q <= pre_valid_d;
			done_q <= finish;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		if (finish) begin
			result_q <= result_d;
		end
		run_id_q <= run_id_d;
		pre_id_q <= pre_id_d;
		pop_rt_q <= pop_rt_d;
		rotate_q <= rotate_d;
	end

	assign done = done_q;
	assign result = result_q;

	// An accepted request always enters the execute cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_EXEC))
		else $error("accepted request did not enter execute");

	// The result strobe coincides with the block being ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A process can only sit in the preempted slot while a real-time one runs.
	a_pre_rt: assert property (@(posedge clk) disable iff (!arst_n)
		pre_valid_q |-> (run_valid_q && run_rt_q))
		else $error("preempted slot held without a running real-time process");

	// A real-time flag is never reported for an idle CPU.
	a_rt_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.running_real_time) |-> result.running_valid)
		else $error("real-time flag on idle result");

endmodule

// ----- src/trqs_ram.sv -----
module trqs_ram #(
	parameter int WIDTH = trqs_pkg::ID_WIDTH_DEFAULT,
	parameter int DEPTH = trqs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/trqs_queue.sv -----
module trqs_queue #(
	parameter int WIDTH = trqs_pkg::ID_WIDTH_DEFAULT,
	parameter int DEPTH = trqs_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       push_data,
	input  logic                   pop,
	output logic [WIDTH-1:0]       pop_data,
	output trqs_pkg::queue_status_t status
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	logic [PtrW-1:0] head_q;
	logic [PtrW-1:0] tail_q;
	logic [CntW-1:0] count_q;
	logic            push_ok;
	logic            pop_ok;

	assign status.empty = (count_q == '0);
	assign status.full = (count_q == CntW'(DEPTH));

	// A push into a full queue or a pop from an empty one is ignored.
	assign push_ok = push && !status.full;
	assign pop_ok = pop && !status.empty;

	// Head, tail and fill count; pointers wrap at the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				tail_q <= (tail_q == PtrW'(DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
			end
			if (pop_ok) begin
				head_q <= (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + PtrW'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + CntW'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	// Entry storage; the popped entry appears on pop_data in the cycle after the pop.
	trqs_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (push_ok),
		.wr_addr(tail_q),
		.wr_data(push_data),
		.rd_en  (pop_ok),
		.rd_addr(head_q),
		.rd_data(pop_data)
	);

endmodule
